// File: rtl/tepd_pkg.sv
// Touch event packet decoder: shared types, event codes and helpers.
// No dependencies; every other file of the block but tepd_if.sv refers to this one.
package tepd_pkg;

  // Coordinate register width; outputs carry the low OUT_COORD_W bits.
  localparam int COORD_BITS  = 16;
  localparam int OUT_COORD_W = 16;
  localparam int TIME_W      = 42;

  // Raw event types and axis codes.
  localparam logic [15:0] TYPE_SYN   = 16'd0;
  localparam logic [15:0] TYPE_ABS   = 16'd3;
  localparam logic [15:0] CODE_X     = 16'd0;
  localparam logic [15:0] CODE_Y     = 16'd1;
  localparam logic [15:0] CODE_SLOT  = 16'd47;
  localparam logic [15:0] CODE_MT_X  = 16'd53;
  localparam logic [15:0] CODE_MT_Y  = 16'd54;
  localparam logic [15:0] CODE_TRACK = 16'd57;
  localparam logic [31:0] TRACK_LIFT = 32'hFFFF_FFFF;

  // ms conversion: micros/1000 as (micros * ceil(2^30/1000)) >> 30, exact below 2^20.
  localparam logic [TIME_W-1:0] MS_PER_S    = TIME_W'(1000);
  localparam int                MICRO_SHIFT = 30;
  localparam logic [20:0]       MICRO_RECIP = 21'd1073742;

  localparam logic [32:0] COORD_MAX = (33'd1 << COORD_BITS) - 33'd1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_AFTER_PREFIX,
    PH_COLLECT
  } tepd_phase_t;

  typedef enum logic [1:0] {
    KIND_PRESS = 2'd0,
    KIND_DRAG  = 2'd1,
    KIND_LIFT  = 2'd2
  } tepd_kind_t;

  typedef struct packed {
    logic [15:0] event_type;
    logic [15:0] event_code;
    logic [31:0] event_value;
    logic [31:0] stamp_seconds;
    logic [19:0] stamp_micros;
  } tepd_event_t;

  typedef struct packed {
    tepd_kind_t               touch_kind;
    logic [OUT_COORD_W-1:0]   current_x;
    logic [OUT_COORD_W-1:0]   current_y;
    logic [OUT_COORD_W-1:0]   pressed_x;
    logic [OUT_COORD_W-1:0]   pressed_y;
    logic [TIME_W-1:0]        time_ms;
    logic [TIME_W-1:0]        pressed_time_ms;
  } tepd_result_t;

  // Clamp a signed 32-bit axis value to 0..2^COORD_BITS-1.
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [31:0] v);
    logic [COORD_BITS-1:0] r;
    if (v[31]) begin
      r = '0;
    end else if ({1'b0, v} > COORD_MAX) begin
      r = COORD_MAX[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // Coordinate register to output width, zero extended or truncated.
  function automatic logic [OUT_COORD_W-1:0] out_coord(input logic [COORD_BITS-1:0] c);
    logic [31:0] ext;
    ext = 32'(c);
    return ext[OUT_COORD_W-1:0];
  endfunction

endpackage

// File: rtl/tepd_if.sv
// Valid/ready channel interfaces for raw touch events and decoded results.
// Depends on nothing; field widths follow the raw event format.
interface tepd_event_if;
  logic        valid;
  logic        ready;
  logic [15:0] event_type;
  logic [15:0] event_code;
  logic [31:0] event_value;
  logic [31:0] stamp_seconds;
  logic [19:0] stamp_micros;

  modport source (output valid, event_type, event_code, event_value,
                  stamp_seconds, stamp_micros, input ready);
  modport sink   (input valid, event_type, event_code, event_value,
                  stamp_seconds, stamp_micros, output ready);
endinterface

interface tepd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  touch_kind;
  logic [15:0] current_x;
  logic [15:0] current_y;
  logic [15:0] pressed_x;
  logic [15:0] pressed_y;
  logic [41:0] time_ms;
  logic [41:0] pressed_time_ms;

  modport source (output valid, touch_kind, current_x, current_y, pressed_x,
                  pressed_y, time_ms, pressed_time_ms, input ready);
  modport sink   (input valid, touch_kind, current_x, current_y, pressed_x,
                  pressed_y, time_ms, pressed_time_ms, output ready);
endinterface

// File: rtl/tepd_time_conv.sv
// Timestamp to milliseconds: seconds*1000 + micros/1000, combinational.
// Depends on tepd_pkg.
module tepd_time_conv (
  input  logic [31:0]                   stamp_seconds,
  input  logic [19:0]                   stamp_micros,
  output logic [tepd_pkg::TIME_W-1:0]   time_ms
);

  logic [tepd_pkg::TIME_W-1:0] sec_ms;
  logic [40:0]                 recip_prod;
  logic [10:0]                 micro_ms;

  // Two constant multiplies side by side, one add behind them.
  assign sec_ms     = tepd_pkg::TIME_W'(stamp_seconds) * tepd_pkg::MS_PER_S;
  assign recip_prod = 41'(stamp_micros) * 41'(tepd_pkg::MICRO_RECIP);
  assign micro_ms   = recip_prod[40:tepd_pkg::MICRO_SHIFT];
  assign time_ms    = sec_ms + tepd_pkg::TIME_W'(micro_ms);

endmodule

// File: rtl/tepd_parser.sv
// Packet parser: phase FSM, coordinate and press registers, result build.
// Depends on tepd_pkg and tepd_time_conv.
module tepd_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  tepd_pkg::tepd_event_t  evt,
  output logic                   emit,
  output tepd_pkg::tepd_result_t res
);

  tepd_pkg::tepd_phase_t          phase_r, phase_nxt;
  tepd_pkg::tepd_kind_t           kind_r, kind_nxt;
  tepd_pkg::tepd_phase_t          cls_phase;
  tepd_pkg::tepd_kind_t           cls_kind;
  logic [tepd_pkg::COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [tepd_pkg::COORD_BITS-1:0] press_x_r, press_x_nxt, press_y_r, press_y_nxt;
  logic [tepd_pkg::TIME_W-1:0]     press_time_r, press_time_nxt;
  logic [tepd_pkg::TIME_W-1:0]     now_ms;
  logic                            is_abs, is_syn, latch_press;

  tepd_time_conv u_time (
    .stamp_seconds (evt.stamp_seconds),
    .stamp_micros  (evt.stamp_micros),
    .time_ms       (now_ms)
  );

  assign is_abs = (evt.event_type == tepd_pkg::TYPE_ABS);
  assign is_syn = (evt.event_type == tepd_pkg::TYPE_SYN);

  // Classification of the packet-opening word.
  always_comb begin
    cls_kind  = kind_r;
    cls_phase = tepd_pkg::PH_IDLE;
    if (is_abs && evt.event_code == tepd_pkg::CODE_TRACK) begin
      cls_kind  = (evt.event_value == tepd_pkg::TRACK_LIFT) ? tepd_pkg::KIND_LIFT
                                                           : tepd_pkg::KIND_PRESS;
      cls_phase = tepd_pkg::PH_COLLECT;
    end else if (is_abs && (evt.event_code == tepd_pkg::CODE_MT_X ||
                            evt.event_code == tepd_pkg::CODE_MT_Y)) begin
      cls_kind  = tepd_pkg::KIND_DRAG;
      cls_phase = tepd_pkg::PH_COLLECT;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    unique case (phase_r)
      tepd_pkg::PH_IDLE: begin
        if (evt.event_code == tepd_pkg::CODE_SLOT) begin
          phase_nxt = tepd_pkg::PH_AFTER_PREFIX;
        end else begin
          phase_nxt = cls_phase;
          kind_nxt  = cls_kind;
        end
      end
      tepd_pkg::PH_COLLECT: begin
        if (is_syn) begin
          phase_nxt = tepd_pkg::PH_IDLE;
        end else if (is_abs && evt.event_code == tepd_pkg::CODE_X) begin
          cur_x_nxt = tepd_pkg::sat_coord(evt.event_value);
        end else if (is_abs && evt.event_code == tepd_pkg::CODE_Y) begin
          cur_y_nxt = tepd_pkg::sat_coord(evt.event_value);
        end
      end
      default: begin
        // after a slot prefix: classify whatever comes
        phase_nxt = cls_phase;
        kind_nxt  = cls_kind;
      end
    endcase
  end

  assign emit        = (phase_r == tepd_pkg::PH_COLLECT) && is_syn;
  assign latch_press = emit && (kind_r == tepd_pkg::KIND_PRESS);

  // Outputs: a press shows its own freshly latched position and time.
  always_comb begin
    press_x_nxt    = latch_press ? cur_x_r : press_x_r;
    press_y_nxt    = latch_press ? cur_y_r : press_y_r;
    press_time_nxt = latch_press ? now_ms  : press_time_r;
    res.touch_kind      = kind_r;
    res.current_x       = tepd_pkg::out_coord(cur_x_r);
    res.current_y       = tepd_pkg::out_coord(cur_y_r);
    res.pressed_x       = tepd_pkg::out_coord(press_x_nxt);
    res.pressed_y       = tepd_pkg::out_coord(press_y_nxt);
    res.time_ms         = now_ms;
    res.pressed_time_ms = press_time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tepd_pkg::PH_IDLE;
      kind_r       <= tepd_pkg::KIND_PRESS;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      press_x_r    <= '0;
      press_y_r    <= '0;
      press_time_r <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      kind_r       <= kind_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      press_x_r    <= press_x_nxt;
      press_y_r    <= press_y_nxt;
      press_time_r <= press_time_nxt;
    end
  end

endmodule

// File: rtl/touch_event_packet_decoder_unit.sv
// Touch event packet decoder, top level.
// Depends on tepd_pkg, tepd_if.sv, tepd_parser and tepd_time_conv.
//
// Usage:
//   in_evt  (sink)   raw touch events: type, code, value, seconds, micros.
//                    One word is accepted on each edge with valid && ready.
//   out_res (source) one decoded gesture per packet, issued on the sync word
//                    that closes it: kind (press/drag/lift), current and press
//                    coordinates, sync time and press time in milliseconds.
//   Slot, tracking-id and mt x/y words open a packet; x/y words update the
//   coordinates; every other word is consumed with no result.
//
// Timing:
//   The accepting edge captures the word in the input register, where it is
//   decoded and converted to ms; when it advances, a closing sync word lands
//   its result in the result register, raising out_res.valid.
//   Throughput 1 word per cycle while no stall holds a sync word; the ms
//   conversion (two constant multiplies, one 42-bit add) sits between the two registers.
//   Reset: parser goes idle, coordinates, press position and press time clear,
//   both registers empty.
//   Stall: while out_res.ready is low and a result waits, a non-sync word keeps
//   flowing; a sync word that closes a packet holds in the input register and
//   in_evt.ready drops until the result register frees.
module touch_event_packet_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  tepd_event_if.sink    in_evt,
  tepd_result_if.source out_res
);

  logic                   s1_valid_r;
  tepd_pkg::tepd_event_t  s1_evt_r;
  logic                   s1_adv;
  logic                   emit;
  tepd_pkg::tepd_result_t res;
  logic                   out_valid_r;
  tepd_pkg::tepd_result_t out_res_r;

  // Word advances unless it makes a result, the result slot is full and out_res.ready is low.
  assign s1_adv       = s1_valid_r && (!emit || !out_valid_r || out_res.ready);
  assign in_evt.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_evt.ready) begin
      s1_valid_r <= in_evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_evt.valid && in_evt.ready) begin
      s1_evt_r.event_type    <= in_evt.event_type;
      s1_evt_r.event_code    <= in_evt.event_code;
      s1_evt_r.event_value   <= in_evt.event_value;
      s1_evt_r.stamp_seconds <= in_evt.stamp_seconds;
      s1_evt_r.stamp_micros  <= in_evt.stamp_micros;
    end
  end

  tepd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_adv),
    .evt   (s1_evt_r),
    .emit  (emit),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.touch_kind      = out_res_r.touch_kind;
  assign out_res.current_x       = out_res_r.current_x;
  assign out_res.current_y       = out_res_r.current_y;
  assign out_res.pressed_x       = out_res_r.pressed_x;
  assign out_res.pressed_y       = out_res_r.pressed_y;
  assign out_res.time_ms         = out_res_r.time_ms;
  assign out_res.pressed_time_ms = out_res_r.pressed_time_ms;

endmodule

// File: tb/sv/touch_event_packet_decoder_unit_test.sv
`timescale 1ns / 100ps
// Testbench for touch_event_packet_decoder_unit: drives raw touch event words and
// scores every decoded gesture against an in-bench decoder or a hand-written gesture. Uses tepd_pkg and tepd_if.sv.
module touch_event_packet_decoder_unit_test;
  import tepd_pkg::*;

  localparam int CLK_HALF      = 6;      // 12 ns period
  localparam int RESET_CYCLES  = 10;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_WORDS  = 2000;
  localparam int CYCLE_LIMIT   = 2000000; // far above the slowest legal run
  localparam int SETTLE_CYCLES = 16;     // leave margin after the drain
  localparam int LONG_HOLD     = 400;
  localparam int REPORT_MAX    = 10;

  localparam logic [41:0] MS_PER_SEC = 42'd1000;
  localparam logic [41:0] US_PER_MS  = 42'd1000;
  localparam logic [15:0] AXIS_MAX   = 16'hFFFF;
  localparam logic [15:0] CODE_ABS_Z = 16'd2;    // an axis the decoder never uses

  typedef struct {
    tepd_event_t  word;
    bit           typed;    // gesture below is written out by hand
    tepd_result_t gesture;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tepd_event_if  ev_if();
  tepd_result_if res_if();

  touch_event_packet_decoder_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_evt  (ev_if),
    .out_res (res_if)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder state mirrored in the bench
  // ---------------------------------------------------------------------------
  tepd_phase_t  trk_phase;
  tepd_kind_t   trk_kind;
  logic [15:0]  pos_x, pos_y;       // current contact position
  logic [15:0]  down_x, down_y;     // position at the last press
  logic [41:0]  down_ms;            // time of the last press
  tepd_result_t gesture_q[$];       // gestures still owed by the block

  // Sideband that travels with each driven word: a hand-written gesture to expect
  bit           note_typed;
  tepd_result_t note_gesture;

  stim_row_t rows[DIRECTED_ROWS];
  int  words_sent     = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  src_steady     = 1'b0;   // sender runs back to back while set
  bit  sink_steady    = 1'b0;   // receiver picks no random stalls while set
  int  sink_wait      = 0;
  bit  long_hold_req  = 1'b0;

  // Signed 32-bit axis value clamped into the 16-bit coordinate range.
  function automatic logic [15:0] clamp_axis(input logic [31:0] v);
    if ($signed(v) < 0) return '0;
    if (v > {16'd0, AXIS_MAX}) return AXIS_MAX;
    return v[15:0];
  endfunction

  // One accepted word through the decoder. emits is set when a sync closes a packet.
  task automatic decode_event(input tepd_event_t w, output bit emits, output tepd_result_t g);
    logic [41:0] ms;
    emits = 1'b0;
    g     = '0;
    ms    = {10'd0, w.stamp_seconds} * MS_PER_SEC + {22'd0, w.stamp_micros} / US_PER_MS;
    if (trk_phase == PH_IDLE && w.event_code == CODE_SLOT) begin
      // slot prefix, any type: classify the word after it
      trk_phase = PH_AFTER_PREFIX;
    end else if (trk_phase != PH_COLLECT) begin
      if (w.event_type == TYPE_ABS && w.event_code == CODE_TRACK) begin
        trk_kind  = (w.event_value == TRACK_LIFT) ? KIND_LIFT : KIND_PRESS;
        trk_phase = PH_COLLECT;
      end else if (w.event_type == TYPE_ABS &&
                   (w.event_code == CODE_MT_X || w.event_code == CODE_MT_Y)) begin
        trk_kind  = KIND_DRAG;
        trk_phase = PH_COLLECT;
      end else begin
        trk_phase = PH_IDLE;
      end
    end else if (w.event_type == TYPE_SYN) begin
      if (trk_kind == KIND_PRESS) begin
        down_x  = pos_x;
        down_y  = pos_y;
        down_ms = ms;
      end
      g.touch_kind      = trk_kind;
      g.current_x       = pos_x;
      g.current_y       = pos_y;
      g.pressed_x       = down_x;
      g.pressed_y       = down_y;
      g.time_ms         = ms;
      g.pressed_time_ms = down_ms;
      emits     = 1'b1;
      trk_phase = PH_IDLE;
    end else if (w.event_type == TYPE_ABS) begin
      // open packet: only plain x/y move the contact, the rest is ignored
      if (w.event_code == CODE_X) begin
        pos_x = clamp_axis(w.event_value);
      end else if (w.event_code == CODE_Y) begin
        pos_y = clamp_axis(w.event_value);
      end
    end
  endtask

  task automatic check_gesture(input bit have_want, input tepd_result_t want,
                               input tepd_result_t got);
    bit bad;
    bad = !have_want
       || want.touch_kind      != got.touch_kind
       || want.current_x       != got.current_x
       || want.current_y       != got.current_y
       || want.pressed_x       != got.pressed_x
       || want.pressed_y       != got.pressed_y
       || want.time_ms         != got.time_ms
       || want.pressed_time_ms != got.pressed_time_ms;
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
        if (have_want) begin
          $display("[%0t] exp kind=%0d cur=%0d,%0d down=%0d,%0d t=%0d down_t=%0d", $time,
                   want.touch_kind, want.current_x, want.current_y, want.pressed_x,
                   want.pressed_y, want.time_ms, want.pressed_time_ms);
        end else begin
          $display("[%0t] gesture arrived with none pending", $time);
        end
        $display("[%0t] got kind=%0d cur=%0d,%0d down=%0d,%0d t=%0d down_t=%0d", $time,
                 got.touch_kind, got.current_x, got.current_y, got.pressed_x,
                 got.pressed_y, got.time_ms, got.pressed_time_ms);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, score every accepted result
  // word. Both handshakes are sampled at the edge, before any NBA lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_words
    tepd_event_t  w;
    tepd_result_t want, got;
    bit           emits;
    if (!rst_n) begin
      trk_phase = PH_IDLE;
      trk_kind  = KIND_PRESS;
      pos_x     = '0;
      pos_y     = '0;
      down_x    = '0;
      down_y    = '0;
      down_ms   = '0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        w.event_type    = ev_if.event_type;
        w.event_code    = ev_if.event_code;
        w.event_value   = ev_if.event_value;
        w.stamp_seconds = ev_if.stamp_seconds;
        w.stamp_micros  = ev_if.stamp_micros;
        decode_event(w, emits, want);
        // hand-written rows still run the decoder so its state stays in step
        if (emits) gesture_q.push_back(note_typed ? note_gesture : want);
      end
      if (res_if.valid && res_if.ready) begin
        got.touch_kind      = tepd_kind_t'(res_if.touch_kind);
        got.current_x       = res_if.current_x;
        got.current_y       = res_if.current_y;
        got.pressed_x       = res_if.pressed_x;
        got.pressed_y       = res_if.pressed_y;
        got.time_ms         = res_if.time_ms;
        got.pressed_time_ms = res_if.pressed_time_ms;
        if (gesture_q.size() == 0) begin
          check_gesture(1'b0, '0, got);
        end else begin
          check_gesture(1'b1, gesture_q.pop_front(), got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random short stalls, occasional long ones, steady stretches, and
  // one long hold-off on request while the sender keeps pushing words.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (long_hold_req) begin
      sink_wait     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (sink_wait > 0) begin
      res_if.ready <= 1'b0;
      sink_wait--;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 299) == 0) sink_steady = !sink_steady;
      if (!sink_steady && $urandom_range(0, 99) < 30) sink_wait = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  function automatic tepd_event_t mk_event(input logic [15:0] t, input logic [15:0] c,
                                           input logic [31:0] v, input logic [31:0] s,
                                           input logic [19:0] u);
    tepd_event_t w;
    w.event_type    = t;
    w.event_code    = c;
    w.event_value   = v;
    w.stamp_seconds = s;
    w.stamp_micros  = u;
    return w;
  endfunction

  // Word with a random timestamp; micros now and then past the legal range.
  function automatic tepd_event_t stamped(input logic [15:0] t, input logic [15:0] c,
                                          input logic [31:0] v);
    logic [31:0] s;
    logic [19:0] u;
    case ($urandom_range(0, 3))
      0:       s = $urandom_range(0, 1000);
      1:       s = 32'hFFFF_FFFF;
      default: s = $urandom;
    endcase
    u = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                    : 20'($urandom_range(0, 999999));
    return mk_event(t, c, v, s, u);
  endfunction

  // Axis values weighted toward the clamp edges.
  function automatic logic [31:0] axis_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return -32'($urandom_range(1, 100));
      2:       return 32'd0;
      3:       return {16'd0, AXIS_MAX};
      4:       return 32'($urandom_range(65536, 70000));
      5:       return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic tepd_result_t mk_gesture(input tepd_kind_t k,
                                              input logic [15:0] cx, input logic [15:0] cy,
                                              input logic [15:0] px, input logic [15:0] py,
                                              input logic [41:0] t, input logic [41:0] pt);
    tepd_result_t g;
    g.touch_kind      = k;
    g.current_x       = cx;
    g.current_y       = cy;
    g.pressed_x       = px;
    g.pressed_y       = py;
    g.time_ms         = t;
    g.pressed_time_ms = pt;
    return g;
  endfunction

  // Offer one word and hold it until the block takes it. valid is only lowered
  // for an idle gap, so it never sees two NBAs in one step.
  task automatic send_word(input tepd_event_t w, input bit typed, input tepd_result_t g);
    int idle;
    idle = src_steady ? 0 : pick_gap();
    if (idle > 0) begin
      ev_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    ev_if.valid         <= 1'b1;
    ev_if.event_type    <= w.event_type;
    ev_if.event_code    <= w.event_code;
    ev_if.event_value   <= w.event_value;
    ev_if.stamp_seconds <= w.stamp_seconds;
    ev_if.stamp_micros  <= w.stamp_micros;
    note_typed          <= typed;
    note_gesture        <= g;
    do @(posedge clk); while (!ev_if.ready);
    words_sent++;
  endtask

  task automatic send_plain(input tepd_event_t w);
    send_word(w, 1'b0, '0);
  endtask

  // Stop offering and wait for every owed gesture. The extra edge lets the
  // monitor log the last accepted word first.
  task automatic wait_drained();
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (gesture_q.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed packet: optional slot prefix, opener, body, sync.
  // Body mixes x/y updates with noise and ignored openers; some packets never close.
  task automatic send_packet();
    int body;
    int pick;
    if ($urandom_range(0, 2) == 0) begin
      send_plain(stamped(($urandom_range(0, 4) == 0) ? 16'($urandom) : TYPE_ABS,
                         CODE_SLOT, $urandom));
    end
    case ($urandom_range(0, 2))
      0: send_plain(stamped(TYPE_ABS, CODE_TRACK,
                            ($urandom_range(0, 2) == 0) ? TRACK_LIFT : $urandom));
      1: send_plain(stamped(TYPE_ABS, CODE_MT_X, axis_value()));
      default: send_plain(stamped(TYPE_ABS, CODE_MT_Y, axis_value()));
    endcase
    body = $urandom_range(0, 5);
    repeat (body) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_plain(stamped(TYPE_ABS, (pick % 2 == 0) ? CODE_X : CODE_Y, axis_value()));
      end else if (pick < 16) begin
        send_plain(stamped(16'($urandom), 16'($urandom), $urandom));
      end else if (pick < 17) begin
        send_plain(stamped(TYPE_ABS, CODE_ABS_Z, $urandom));
      end else begin
        case ($urandom_range(0, 2))
          0:       send_plain(stamped(TYPE_ABS, CODE_SLOT, $urandom));
          1:       send_plain(stamped(TYPE_ABS, CODE_TRACK, TRACK_LIFT));
          default: send_plain(stamped(TYPE_ABS, CODE_MT_X, axis_value()));
        endcase
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send_plain(stamped(TYPE_SYN, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0,
                         $urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    tepd_result_t none;
    bit           hold_done;
    bit           pause_done;
    int           pick;
    none       = '0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    rst_n               = 1'b0;
    ev_if.valid         = 1'b0;
    ev_if.event_type    = '0;
    ev_if.event_code    = '0;
    ev_if.event_value   = '0;
    ev_if.stamp_seconds = '0;
    ev_if.stamp_micros  = '0;
    res_if.ready        = 1'b0;
    note_typed          = 1'b0;
    note_gesture        = '0;

    // Directed rows. Hand-written gestures only where the value is obvious.
    // sync with nothing open: dropped
    rows[0]  = '{mk_event(TYPE_SYN, 16'd0, 32'd0, 32'hFFFF_FFFF, 20'd0), 1'b0, none};
    // press, x clamps high, y clamps low, time zero
    rows[1]  = '{mk_event(TYPE_ABS, CODE_TRACK, 32'd5, 32'd0, 20'd0), 1'b0, none};
    rows[2]  = '{mk_event(TYPE_ABS, CODE_X, 32'h7FFF_FFFF, 32'd0, 20'd0), 1'b0, none};
    rows[3]  = '{mk_event(TYPE_ABS, CODE_Y, 32'h8000_0000, 32'd0, 20'd0), 1'b0, none};
    rows[4]  = '{mk_event(TYPE_SYN, 16'd0, 32'd0, 32'd0, 20'd0), 1'b1,
                 mk_gesture(KIND_PRESS, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 42'd0, 42'd0)};
    // slot prefix then mt x drag; max timestamp
    rows[5]  = '{mk_event(TYPE_ABS, CODE_SLOT, 32'd0, 32'd0, 20'd0), 1'b0, none};
    rows[6]  = '{mk_event(TYPE_ABS, CODE_MT_X, 32'd100, 32'd0, 20'd0), 1'b0, none};
    rows[7]  = '{mk_event(TYPE_ABS, CODE_X, 32'd65535, 32'd0, 20'd0), 1'b0, none};
    rows[8]  = '{mk_event(TYPE_ABS, CODE_Y, 32'd65536, 32'd0, 20'd0), 1'b0, none};
    rows[9]  = '{mk_event(TYPE_SYN, 16'd0, 32'd0, 32'hFFFF_FFFF, 20'd999999), 1'b1,
                 mk_gesture(KIND_DRAG, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
                            42'd4294967295999, 42'd0)};
    // slot prefix of sync type, lift; nested tracking id and slot ignored;
    // micros past range divides as given
    rows[10] = '{mk_event(TYPE_SYN, CODE_SLOT, 32'd0, 32'd0, 20'd0), 1'b0, none};
    rows[11] = '{mk_event(TYPE_ABS, CODE_TRACK, TRACK_LIFT, 32'd0, 20'd0), 1'b0, none};
    rows[12] = '{mk_event(TYPE_ABS, CODE_X, 32'hFFFF_FFFF, 32'd0, 20'd0), 1'b0, none};
    rows[13] = '{mk_event(TYPE_ABS, CODE_Y, 32'd0, 32'd0, 20'd0), 1'b0, none};
    rows[14] = '{mk_event(TYPE_ABS, CODE_TRACK, 32'd7, 32'd0, 20'd0), 1'b0, none};
    rows[15] = '{mk_event(TYPE_ABS, CODE_SLOT, 32'd0, 32'd0, 20'd0), 1'b0, none};
    rows[16] = '{mk_event(TYPE_SYN, 16'd0, 32'd0, 32'd1, 20'hFFFFF), 1'b1,
                 mk_gesture(KIND_LIFT, 16'd0, 16'd0, 16'hFFFF, 16'd0, 42'd2048, 42'd0)};
    // two slots in a row: second one is classified and dropped
    rows[17] = '{mk_event(TYPE_ABS, CODE_SLOT, 32'd0, 32'd0, 20'd0), 1'b0, none};
    rows[18] = '{mk_event(TYPE_ABS, CODE_SLOT, 32'd0, 32'd0, 20'd0), 1'b0, none};
    // unused axis while idle: dropped
    rows[19] = '{mk_event(TYPE_ABS, CODE_ABS_Z, 32'd3, 32'd0, 20'd0), 1'b0, none};
    // mt y drag; all-ones type and code inside the packet are ignored
    rows[20] = '{mk_event(TYPE_ABS, CODE_MT_Y, 32'd9, 32'd0, 20'd0), 1'b0, none};
    rows[21] = '{mk_event(16'hFFFF, 16'hFFFF, 32'd500, 32'd0, 20'd0), 1'b0, none};
    rows[22] = '{mk_event(TYPE_SYN, 16'd0, 32'd0, 32'd2, 20'd999), 1'b1,
                 mk_gesture(KIND_DRAG, 16'd0, 16'd0, 16'hFFFF, 16'd0, 42'd2000, 42'd0)};
    // press with no coordinate words latches the current position and time
    rows[23] = '{mk_event(TYPE_ABS, CODE_TRACK, 32'd0, 32'd0, 20'd0), 1'b0, none};
    rows[24] = '{mk_event(TYPE_SYN, 16'd0, 32'd0, 32'd3, 20'd1000), 1'b1,
                 mk_gesture(KIND_PRESS, 16'd0, 16'd0, 16'd0, 16'd0, 42'd3001, 42'd3001)};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].gesture);
    wait_drained();

    // Random part: mostly packets, plus stray words and broken prefixes.
    while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
      if (!hold_done && words_sent > DIRECTED_ROWS + 500) begin
        long_hold_req = 1'b1;   // receiver backs off; input must stall
        hold_done     = 1'b1;
      end
      if (!pause_done && words_sent > DIRECTED_ROWS + 1200) begin
        wait_drained();
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) src_steady = !src_steady;
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        send_packet();
      end else if (pick < 18) begin
        send_plain(stamped(16'($urandom), 16'($urandom), $urandom));
      end else if (pick < 19) begin
        send_plain(stamped(TYPE_SYN, 16'd0, $urandom));
      end else begin
        send_plain(stamped(16'($urandom), CODE_SLOT, $urandom));
        send_plain(stamped(TYPE_ABS, CODE_SLOT, $urandom));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && gesture_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
